// ===== rtl/core/dssm_pkg.sv =====
// dssm_pkg: shared types and constants for the dual stack shared memory block.
// No dependencies; used by dssm_seq, dual_stack_shared_memory and tb.
`default_nettype none

package dssm_pkg;

  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned SIZE_BITS = 7;
  localparam int unsigned DATA_BITS = 32;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_POP     = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_DISPLAY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ADDR,
    S_READ,
    S_EMIT
  } seq_state_e;

  typedef struct packed {
    status_e              status;
    logic [DATA_BITS-1:0] data;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/dssm_store.sv =====
// dssm_store: single-port word memory shared by both stacks, registered read.
// Depends on nothing; instantiated by dual_stack_shared_memory.
`default_nettype none

module dssm_store #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WORD_BITS-1:0]     wdata_i,
  output logic      [WORD_BITS-1:0]     rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/dssm_seq.sv =====
// dssm_seq: sequencer, stack counters, size register and the shared slot address unit.
// Depends on dssm_pkg; drives dssm_store and feeds the output register in the top level.
`default_nettype none

module dssm_seq #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dssm_pkg::SIZE_BITS-1:0]      cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          action_i,
  input  wire logic                                stack_select_i,
  input  wire logic signed [dssm_pkg::DATA_BITS-1:0] push_value_i,
  output logic      [$clog2(DEPTH)-1:0]            mem_addr_o,
  output logic                                     mem_we_o,
  output logic      [WORD_BITS-1:0]                mem_wdata_o,
  input  wire logic [WORD_BITS-1:0]                mem_rdata_i,
  output logic                                     res_valid_o,
  output dssm_pkg::res_t                           res_o,
  input  wire logic                                res_take_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = dssm_pkg::DATA_BITS;

  dssm_pkg::seq_state_e state_q, state_d;
  dssm_pkg::action_e    act_q, act_d;
  logic                 sel_q, sel_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [CW-1:0]        lcnt_q, lcnt_d, ucnt_q, ucnt_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic [dssm_pkg::SIZE_BITS-1:0] size_q, size_d;
  dssm_pkg::res_t       res_q, res_d;

  logic [CW-1:0]        used_size;
  logic [CW-1:0]        cnt;
  logic [CW:0]          fill;
  logic                 full;
  logic [CW-1:0]        slot_pos;
  logic [CW-1:0]        slot_full;
  logic [WORD_BITS+DW-1:0] rd_wide, echo_wide;
  logic [DW-1:0]        rd_word, echo_word;
  logic                 rd_last;

  assign used_size = (size_q > dssm_pkg::SIZE_BITS'(DEPTH)) ? CW'(DEPTH) : size_q[CW-1:0];
  assign cnt       = sel_q ? ucnt_q : lcnt_q;
  assign fill      = {1'b0, lcnt_q} + {1'b0, ucnt_q};
  assign full      = fill >= {1'b0, used_size};

  // shared slot unit: lower stack at pos, upper stack at size-1-pos
  assign slot_pos  = (state_q == dssm_pkg::S_EXEC) ? cnt : pos_q;
  assign slot_full = sel_q ? (used_size - CW'(1) - slot_pos) : slot_pos;
  assign mem_addr_o  = slot_full[AW-1:0];
  assign mem_wdata_o = word_q;

  assign rd_wide   = {{DW{1'b0}}, mem_rdata_i};
  assign rd_word   = rd_wide[DW-1:0];
  assign echo_wide = {{DW{1'b0}}, word_q};
  assign echo_word = echo_wide[DW-1:0];
  assign rd_last   = (act_q != dssm_pkg::ACT_DISPLAY) || ((pos_q + CW'(1)) == cnt);

  assign in_stall_o  = (state_q != dssm_pkg::S_IDLE);
  assign res_valid_o = (state_q == dssm_pkg::S_EMIT);
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dssm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = dssm_pkg::S_EXEC;
        end
      end
      dssm_pkg::S_EXEC: begin
        if (act_q == dssm_pkg::ACT_PUSH || cnt == '0) begin
          state_d = dssm_pkg::S_EMIT;
        end else begin
          state_d = dssm_pkg::S_ADDR;
        end
      end
      dssm_pkg::S_ADDR: state_d = dssm_pkg::S_READ;
      dssm_pkg::S_READ: state_d = dssm_pkg::S_EMIT;
      dssm_pkg::S_EMIT: begin
        if (res_take_i) begin
          state_d = res_q.last ? dssm_pkg::S_IDLE : dssm_pkg::S_ADDR;
        end
      end
      default: state_d = dssm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    act_d    = act_q;
    sel_d    = sel_q;
    word_d   = word_q;
    lcnt_d   = lcnt_q;
    ucnt_d   = ucnt_q;
    pos_d    = pos_q;
    size_d   = size_q;
    res_d    = res_q;
    mem_we_o = 1'b0;
    case (state_q)
      dssm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          act_d  = dssm_pkg::action_e'(action_i);
          sel_d  = stack_select_i;
          word_d = WORD_BITS'(push_value_i);
        end
      end
      dssm_pkg::S_EXEC: begin
        if (act_q == dssm_pkg::ACT_PUSH) begin
          if (full) begin
            res_d = '{status: dssm_pkg::ST_OVERFLOW, data: echo_word, last: 1'b1};
          end else begin
            mem_we_o = 1'b1;
            if (sel_q) begin
              ucnt_d = ucnt_q + CW'(1);
            end else begin
              lcnt_d = lcnt_q + CW'(1);
            end
            res_d = '{status: dssm_pkg::ST_OK, data: echo_word, last: 1'b1};
          end
        end else if (cnt == '0) begin
          res_d = '{status: dssm_pkg::ST_EMPTY, data: '0, last: 1'b1};
        end else if (act_q == dssm_pkg::ACT_DISPLAY) begin
          pos_d = '0;
        end else begin
          pos_d = cnt - CW'(1);
          if (act_q == dssm_pkg::ACT_POP) begin
            if (sel_q) begin
              ucnt_d = ucnt_q - CW'(1);
            end else begin
              lcnt_d = lcnt_q - CW'(1);
            end
          end
        end
      end
      dssm_pkg::S_READ: begin
        res_d = '{status: dssm_pkg::ST_OK, data: rd_word, last: rd_last};
      end
      dssm_pkg::S_EMIT: begin
        if (res_take_i && !res_q.last) begin
          pos_d = pos_q + CW'(1);
        end
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      size_d = cfg_wdata_i;
      lcnt_d = '0;
      ucnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dssm_pkg::S_IDLE;
      lcnt_q  <= '0;
      ucnt_q  <= '0;
      size_q  <= dssm_pkg::SIZE_RESET;
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      ucnt_q  <= ucnt_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    sel_q  <= sel_d;
    word_q <= word_d;
    pos_q  <= pos_d;
    res_q  <= res_d;
  end

  ap_fill_in_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= {1'b0, used_size})
    else $error("stacks overlap");

  ap_write_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (!full && state_q == dssm_pkg::S_EXEC))
    else $error("write without free slot");

  ap_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == dssm_pkg::S_EXEC)
    else $error("accepted word not executed");

  ap_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dssm_pkg::S_EMIT && !res_take_i)
      |=> (state_q == dssm_pkg::S_EMIT && $stable(res_q)))
    else $error("pending result lost");

  ap_disp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dssm_pkg::S_READ && act_q == dssm_pkg::ACT_DISPLAY) |-> pos_q < cnt)
    else $error("display past top of stack");

endmodule

`default_nettype wire

// ===== rtl/core/dual_stack_shared_memory.sv =====
// dual_stack_shared_memory: top level, two stacks in one shared word memory.
// Depends on dssm_pkg, dssm_store and dssm_seq.
`default_nettype none

// Two stacks share DEPTH words: the lower stack grows up from entry 0, the upper
// stack grows down from entry size-1, where size is the size register clamped to
// DEPTH (writing it empties both stacks). One word is worked on at a time by a
// small sequencer around one slot address unit and a single-port memory with a
// registered read. Push, overflowing push and any access to an empty stack go
// from accept through EXEC to EMIT; pop and peek go through EXEC, ADDR, READ and
// EMIT; display goes through EXEC, then ADDR, READ and EMIT per element, one
// result per element. An output register holds each result, so the next word
// is accepted while the last result of the previous one still waits downstream.
module dual_stack_shared_memory #(
  parameter int unsigned DEPTH     = dssm_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = dssm_pkg::WORD_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [dssm_pkg::SIZE_BITS-1:0]        cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [1:0]                            action_i,
  input  wire logic                                  stack_select_i,
  input  wire logic signed [dssm_pkg::DATA_BITS-1:0] push_value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [1:0]                                 status_o,
  output logic signed [dssm_pkg::DATA_BITS-1:0]      data_out_o,
  output logic                                       last_o
);

  logic [$clog2(DEPTH)-1:0] mem_addr;
  logic                     mem_we;
  logic [WORD_BITS-1:0]     mem_wdata;
  logic [WORD_BITS-1:0]     mem_rdata;
  logic                     res_valid;
  dssm_pkg::res_t           res;
  logic                     res_take;

  logic                     out_valid_q, out_valid_d;
  dssm_pkg::res_t           out_q;

  dssm_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mem_we),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  dssm_seq #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .mem_addr_o     (mem_addr),
    .mem_we_o       (mem_we),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_take_i     (res_take)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign data_out_o  = out_q.data;
  assign last_o      = out_q.last;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for dual_stack_shared_memory, two stacks in one word store.
// A scripted sequence, then random push/pop/peek/display phases at several sizes,
// each checked against a local predictor. Depends on dssm_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import dssm_pkg::*;

  typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    action_e     act;
    logic        sel;
    logic [31:0] val;
    logic        typed;
    status_e     status;
    logic [31:0] data;
  } script_row_t;

  localparam int SCRIPT_LEN = 27;
  localparam int RAND_WORDS = 300;

  // size rows carry the new size in val
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_WORD, ACT_POP,     1'b0, 32'hDEAD_BEEF, 1'b1, ST_EMPTY,    32'h0000_0000},
    '{ROW_WORD, ACT_PEEK,    1'b1, 32'hFFFF_FFFF, 1'b1, ST_EMPTY,    32'h0000_0000},
    '{ROW_WORD, ACT_DISPLAY, 1'b0, 32'h1234_5678, 1'b1, ST_EMPTY,    32'h0000_0000},
    '{ROW_WORD, ACT_DISPLAY, 1'b1, 32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
    '{ROW_WORD, ACT_PUSH,    1'b0, 32'h7FFF_FFFF, 1'b1, ST_OK,       32'h7FFF_FFFF},
    '{ROW_WORD, ACT_PUSH,    1'b0, 32'h8000_0000, 1'b1, ST_OK,       32'h8000_0000},
    '{ROW_WORD, ACT_PUSH,    1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK,       32'hFFFF_FFFF},
    '{ROW_WORD, ACT_PUSH,    1'b1, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
    '{ROW_WORD, ACT_PEEK,    1'b0, 32'h5555_5555, 1'b1, ST_OK,       32'h8000_0000},
    '{ROW_WORD, ACT_DISPLAY, 1'b0, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
    '{ROW_WORD, ACT_DISPLAY, 1'b1, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
    '{ROW_WORD, ACT_POP,     1'b0, 32'hAAAA_AAAA, 1'b1, ST_OK,       32'h8000_0000},
    '{ROW_WORD, ACT_POP,     1'b1, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
    '{ROW_WORD, ACT_PEEK,    1'b1, 32'h0000_0000, 1'b1, ST_OK,       32'hFFFF_FFFF},
    '{ROW_SIZE, ACT_PUSH,    1'b0, 32'd1,         1'b0, ST_OK,       32'h0000_0000},
    '{ROW_WORD, ACT_PEEK,    1'b1, 32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
    '{ROW_WORD, ACT_PUSH,    1'b0, 32'hA5A5_A5A5, 1'b1, ST_OK,       32'hA5A5_A5A5},
    '{ROW_WORD, ACT_PUSH,    1'b1, 32'h5A5A_5A5A, 1'b1, ST_OVERFLOW, 32'h5A5A_5A5A},
    '{ROW_WORD, ACT_POP,     1'b0, 32'h0000_0000, 1'b1, ST_OK,       32'hA5A5_A5A5},
    '{ROW_WORD, ACT_PUSH,    1'b1, 32'h1234_5678, 1'b1, ST_OK,       32'h1234_5678},
    '{ROW_WORD, ACT_DISPLAY, 1'b1, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
    '{ROW_SIZE, ACT_PUSH,    1'b0, 32'd0,         1'b0, ST_OK,       32'h0000_0000},
    '{ROW_WORD, ACT_PUSH,    1'b0, 32'hFFFF_FFFF, 1'b1, ST_OVERFLOW, 32'hFFFF_FFFF},
    '{ROW_WORD, ACT_DISPLAY, 1'b0, 32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
    '{ROW_SIZE, ACT_PUSH,    1'b0, 32'd127,       1'b0, ST_OK,       32'h0000_0000},
    '{ROW_WORD, ACT_PUSH,    1'b1, 32'hC000_0000, 1'b0, ST_OK,       32'h0000_0000},
    '{ROW_WORD, ACT_DISPLAY, 1'b1, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [SIZE_BITS-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           action_i;
  logic                 stack_select_i;
  logic [31:0]          push_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic [31:0]          data_out_o;
  logic                 last_o;

  logic [31:0]  store_img [DEPTH_DEF];
  int unsigned  lower_depth;
  int unsigned  upper_depth;
  int unsigned  size_reg;
  res_t         owed_results [$];
  int unsigned  err_count;
  bit           tx_steady;

  dual_stack_shared_memory DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // apply one word to the stack image; optionally queue the results it yields
  task automatic stack_step(input action_e act, input logic sel, input logic [31:0] val,
                            input bit record);
    int unsigned size;
    int unsigned cnt;
    res_t        r;
    size = (size_reg > DEPTH_DEF) ? DEPTH_DEF : size_reg;
    cnt  = sel ? upper_depth : lower_depth;
    r.status = ST_OK;
    r.data   = val;
    r.last   = 1'b1;
    if (act == ACT_PUSH) begin
      if (lower_depth + upper_depth >= size) begin
        r.status = ST_OVERFLOW;
      end else begin
        store_img[sel ? size - 1 - cnt : cnt] = val;
        if (sel) upper_depth++;
        else lower_depth++;
      end
      if (record) owed_results.push_back(r);
    end else if (cnt == 0) begin
      r.status = ST_EMPTY;
      r.data   = '0;
      if (record) owed_results.push_back(r);
    end else if (act != ACT_DISPLAY) begin
      r.data = store_img[sel ? size - cnt : cnt - 1];
      if (act == ACT_POP) begin
        if (sel) upper_depth--;
        else lower_depth--;
      end
      if (record) owed_results.push_back(r);
    end else begin
      for (int unsigned p = 0; p < cnt; p++) begin
        r.data = store_img[sel ? size - 1 - p : p];
        r.last = (p + 1 == cnt);
        if (record) owed_results.push_back(r);
      end
    end
  endtask

  task automatic send_word(input action_e act, input logic sel, input logic [31:0] val,
                           input bit typed, input res_t fixed);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    action_i       <= act;
    stack_select_i <= sel;
    push_value_i   <= val;
    do @(posedge clk_i); while (in_stall_o);
    if (typed) owed_results.push_back(fixed);
    stack_step(act, sel, val, !typed);
    gap = tx_steady ? 0 : pause_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // only once the block has drained
  task automatic write_size(input logic [SIZE_BITS-1:0] v);
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg    = 32'(v);
    lower_depth = 0;
    upper_depth = 0;
  endtask

  initial begin
    int unsigned          sent;
    int unsigned          phase;
    int unsigned          len;
    int unsigned          push_pct;
    int unsigned          pick;
    logic [SIZE_BITS-1:0] sz;
    action_e              act;
    logic [31:0]          val;
    res_t                 fixed;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_PUSH;
    stack_select_i <= 1'b0;
    push_value_i   <= '0;
    size_reg    = 32'(SIZE_RESET);
    lower_depth = 0;
    upper_depth = 0;
    err_count   = 0;
    tx_steady   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_SIZE) begin
        write_size(SCRIPT[i].val[SIZE_BITS-1:0]);
      end else begin
        fixed.status = SCRIPT[i].status;
        fixed.data   = SCRIPT[i].data;
        fixed.last   = 1'b1;
        send_word(SCRIPT[i].act, SCRIPT[i].sel, SCRIPT[i].val, SCRIPT[i].typed, fixed);
      end
    end

    // first phase fills the full store so overflow and long displays are hit
    sent  = 0;
    phase = 0;
    fixed = '0;
    while (sent < RAND_WORDS) begin
      if (phase == 0) begin
        sz       = 7'd127;
        push_pct = 85;
        len      = 90;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3) sz = SIZE_BITS'($urandom_range(0, 2));
        else if (pick < 7) sz = SIZE_BITS'($urandom_range(3, 12));
        else if (pick < 9) sz = SIZE_BITS'($urandom_range(13, 64));
        else sz = SIZE_BITS'($urandom_range(65, 127));
        push_pct = $urandom_range(35, 75);
        len      = $urandom_range(20, 50);
      end
      write_size(sz);
      tx_steady = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        if ($urandom_range(0, 99) < push_pct) begin
          act = ACT_PUSH;
        end else begin
          pick = $urandom_range(0, 9);
          act  = (pick < 4) ? ACT_POP : (pick < 7) ? ACT_PEEK : ACT_DISPLAY;
        end
        pick = $urandom_range(0, 19);
        val  = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7FFF_FFFF : $urandom;
        send_word(act, 1'($urandom_range(0, 1)), val, 1'b0, fixed);
        sent++;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // result side: random stalls plus two long hold-offs
  initial begin
    int unsigned seen;
    int unsigned hold_left;
    int unsigned stall_left;
    bit          rx_steady;
    res_t        want;
    seen       = 0;
    hold_left  = 0;
    stall_left = 0;
    rx_steady  = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected word: status %0d data %h last %b",
                     status_o, data_out_o, last_o);
        end else begin
          want = owed_results.pop_front();
          if (status_o !== want.status || data_out_o !== want.data || last_o !== want.last) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: want status %0d data %h last %b, got %0d %h %b",
                       want.status, want.data, want.last, status_o, data_out_o, last_o);
          end
        end
        seen++;
        if (seen == 60 || seen == 400) hold_left = 150;
        if (seen % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!rx_steady) stall_left = pause_len();
      end
    end
  end

endmodule
